### hw/rtl/bcv_pkg.sv
// ----------------------------------------------------------------------------
// bcv_pkg: shared definitions for the battery charge lookup
// Table contents, field widths, type codes and the queue entry format.
// ----------------------------------------------------------------------------
package bcv_pkg;

    localparam int LUT_SLOTS   = 16;
    localparam int IDX_W       = $clog2(LUT_SLOTS);
    localparam int MV_W        = 16;
    localparam int PCT_W       = 7;
    localparam int TYPE_W      = 2;
    localparam int PROD_W      = MV_W + PCT_W;
    localparam int QUO_W       = PCT_W;
    localparam int DIV_STAGES  = QUO_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IRON_PHOSPHATE_ENTRIES = 11;
    localparam int POLYMER_ENTRIES        = 6;

    localparam logic [PCT_W-1:0]  TOP_CAP   = 7'd99;
    localparam logic [PCT_W-1:0]  MAX_PCT   = 7'd100;
    localparam logic [TYPE_W-1:0] TYPE_LFP  = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_LIPO = 2'd1;

    // Iron phosphate table, descending but for the entry at 26400 mV.
    localparam logic [MV_W-1:0] LFP_MV [LUT_SLOTS] = '{
        16'd27200, 16'd26800, 16'd26600, 16'd26100,
        16'd26400, 16'd26100, 16'd26000, 16'd25800,
        16'd25600, 16'd24000, 16'd20000, 16'd0,
        16'd0,     16'd0,     16'd0,     16'd0
    };
    localparam logic [PCT_W-1:0] LFP_PCT [LUT_SLOTS] = '{
        7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30,
        7'd20,  7'd10, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0
    };

    localparam logic [MV_W-1:0] LIPO_MV [LUT_SLOTS] = '{
        16'd25200, 16'd24500, 16'd23000, 16'd21000,
        16'd20000, 16'd18000, 16'd0,     16'd0,
        16'd0,     16'd0,     16'd0,     16'd0,
        16'd0,     16'd0,     16'd0,     16'd0
    };
    localparam logic [PCT_W-1:0] LIPO_PCT [LUT_SLOTS] = '{
        7'd100, 7'd90, 7'd80, 7'd20, 7'd10, 7'd0, 7'd0, 7'd0,
        7'd0,   7'd0,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0, 7'd0
    };

    // One classified item: result = base + floor(dv * step / span),
    // capped at TOP_CAP when cap is set.
    typedef struct packed {
        logic [PCT_W-1:0] base;
        logic             cap;
        logic [MV_W-1:0]  dv;
        logic [PCT_W-1:0] step;
        logic [MV_W-1:0]  span;
    } op_t;

endpackage

### hw/rtl/bcv_front.sv
// ----------------------------------------------------------------------------
// bcv_front: table scan and classification
// Finds the first table entry at or below the voltage and turns the item
// into a base percent plus an interpolation job.
// ----------------------------------------------------------------------------
module bcv_front (
    input  logic [bcv_pkg::MV_W-1:0]   voltage_mv,
    input  logic [bcv_pkg::TYPE_W-1:0] chem_code,
    output bcv_pkg::op_t               op
);

    logic [bcv_pkg::MV_W-1:0]  mv  [bcv_pkg::LUT_SLOTS];
    logic [bcv_pkg::PCT_W-1:0] pct [bcv_pkg::LUT_SLOTS];
    logic [bcv_pkg::LUT_SLOTS-1:0] hit;
    logic                      known;
    logic                      found;
    logic [bcv_pkg::IDX_W-1:0] idx;
    logic [bcv_pkg::IDX_W-1:0] prev_idx;

    always_comb begin
        known = 1'b1;
        for (int i = 0; i < bcv_pkg::LUT_SLOTS; i++) begin
            mv[i]  = '0;
            pct[i] = '0;
            hit[i] = 1'b0;
        end
        case (chem_code)
            bcv_pkg::TYPE_LFP: begin
                for (int i = 0; i < bcv_pkg::LUT_SLOTS; i++) begin
                    mv[i]  = bcv_pkg::LFP_MV[i];
                    pct[i] = bcv_pkg::LFP_PCT[i];
                    hit[i] = (i < bcv_pkg::IRON_PHOSPHATE_ENTRIES) &&
                             (bcv_pkg::LFP_MV[i] <= voltage_mv);
                end
            end
            bcv_pkg::TYPE_LIPO: begin
                for (int i = 0; i < bcv_pkg::LUT_SLOTS; i++) begin
                    mv[i]  = bcv_pkg::LIPO_MV[i];
                    pct[i] = bcv_pkg::LIPO_PCT[i];
                    hit[i] = (i < bcv_pkg::POLYMER_ENTRIES) &&
                             (bcv_pkg::LIPO_MV[i] <= voltage_mv);
                end
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // Priority pick of the lowest hit index.
    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int i = bcv_pkg::LUT_SLOTS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                found = 1'b1;
                idx   = bcv_pkg::IDX_W'(i);
            end
        end
        prev_idx = idx - bcv_pkg::IDX_W'(1);
    end

    always_comb begin
        op.base = '0;
        op.cap  = 1'b0;
        op.dv   = '0;
        op.step = '0;
        op.span = bcv_pkg::MV_W'(1);
        if (known && found) begin
            if (mv[idx] == voltage_mv) begin
                op.base = pct[idx];
            end else if (idx == '0) begin
                op.base = bcv_pkg::TOP_CAP;
            end else begin
                op.base = pct[idx];
                op.cap  = 1'b1;
                op.dv   = voltage_mv - mv[idx];
                op.span = mv[prev_idx] - mv[idx];
                // rising percent between neighbors counts as no step
                op.step = (pct[prev_idx] > pct[idx]) ? pct[prev_idx] - pct[idx] : '0;
            end
        end
    end

endmodule

### hw/rtl/bcv_fifo.sv
// ----------------------------------------------------------------------------
// bcv_fifo: classified item queue
// Short register queue that decouples the scan from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module bcv_fifo (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  bcv_pkg::op_t in_op,
    output logic         out_valid,
    input  logic         out_pop,
    output bcv_pkg::op_t out_op
);

    bcv_pkg::op_t               mem [bcv_pkg::QUEUE_DEPTH];
    logic [bcv_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bcv_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bcv_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       push;
    logic                       pop;

    assign in_ready  = (count_reg != bcv_pkg::QCNT_W'(bcv_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_op    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + bcv_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + bcv_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + bcv_pkg::QCNT_W'(push) - bcv_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_op;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bcv_pkg::QCNT_W'(bcv_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> count_reg ==
            $past(count_reg) + bcv_pkg::QCNT_W'($past(push)) - bcv_pkg::QCNT_W'($past(pop)))
        else $error("queue count out of step with push and pop");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == bcv_pkg::QCNT_W'(bcv_pkg::QUEUE_DEPTH))
            |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");
`endif

endmodule

### hw/rtl/bcv_back.sv
// ----------------------------------------------------------------------------
// bcv_back: interpolation pipeline
// Multiply, restoring divide one quotient bit per stage, add and cap.
// ----------------------------------------------------------------------------
module bcv_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_pop,
    input  bcv_pkg::op_t              in_op,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [bcv_pkg::PCT_W-1:0] charge_percent
);

    localparam int LAST = bcv_pkg::DIV_STAGES;

    logic                       vld_reg  [LAST+2];
    logic [bcv_pkg::PROD_W-1:0] rem_reg  [LAST+1];
    logic [bcv_pkg::MV_W-1:0]   span_reg [LAST+1];
    logic [bcv_pkg::QUO_W-1:0]  quo_reg  [LAST+1];
    logic [bcv_pkg::PCT_W-1:0]  base_reg [LAST+1];
    logic                       cap_reg  [LAST+1];
    logic [bcv_pkg::PCT_W-1:0]  out_reg;
    logic [bcv_pkg::PROD_W-1:0] trial [LAST+1];
    logic                       ge    [LAST+1];
    logic [bcv_pkg::PCT_W:0]    sum;
    logic                       adv;

    // Whole pipeline advances unless the output register holds an untaken item.
    assign adv            = !vld_reg[LAST+1] || out_ready;
    assign in_pop         = adv;
    assign out_valid      = vld_reg[LAST+1];
    assign charge_percent = out_reg;

    always_comb begin
        trial[0] = '0;
        ge[0]    = 1'b0;
        for (int j = 1; j <= LAST; j++) begin
            trial[j] = bcv_pkg::PROD_W'(span_reg[j-1]) << (LAST - j);
            ge[j]    = rem_reg[j-1] >= trial[j];
        end
        sum = {1'b0, base_reg[LAST]} + {1'b0, quo_reg[LAST]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= LAST + 1; j++) begin
                vld_reg[j] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int j = 1; j <= LAST + 1; j++) begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= bcv_pkg::PROD_W'(in_op.dv) * bcv_pkg::PROD_W'(in_op.step);
            span_reg[0] <= in_op.span;
            quo_reg[0]  <= '0;
            base_reg[0] <= in_op.base;
            cap_reg[0]  <= in_op.cap;
            for (int j = 1; j <= LAST; j++) begin
                rem_reg[j]  <= ge[j] ? rem_reg[j-1] - trial[j] : rem_reg[j-1];
                quo_reg[j]  <= quo_reg[j-1] |
                               (ge[j] ? bcv_pkg::QUO_W'(1) << (LAST - j) : '0);
                span_reg[j] <= span_reg[j-1];
                base_reg[j] <= base_reg[j-1];
                cap_reg[j]  <= cap_reg[j-1];
            end
            if (cap_reg[LAST] && sum > {1'b0, bcv_pkg::TOP_CAP}) begin
                out_reg <= bcv_pkg::TOP_CAP;
            end else begin
                out_reg <= sum[bcv_pkg::PCT_W-1:0];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> charge_percent <= bcv_pkg::MAX_PCT)
        else $error("charge above full scale");

    a_rem_below_span: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[LAST] |-> rem_reg[LAST] < bcv_pkg::PROD_W'(span_reg[LAST]))
        else $error("division remainder not below span");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid && $stable(out_reg))
        else $error("stalled result changed");
`endif

endmodule

### hw/rtl/battery_charge_from_voltage_lut.sv
// ----------------------------------------------------------------------------
// battery_charge_from_voltage_lut: battery state of charge from voltage
// Streaming lookup with linear interpolation over fixed per-type tables.
// ----------------------------------------------------------------------------
// Send a voltage in millivolts on s_tdata and the battery type on s_tuser
// (0 iron phosphate, 1 polymer, other codes read as 0 %); one charge percent
// comes back per item, in order. The block takes one item per clock cycle
// as long as the result side keeps up. The stages from the accepting edge
// to m_tvalid are the queue write, the multiply stage, seven restoring
// divider stages (one quotient bit each) and the output register. A four
// entry queue sits between the table scan and the arithmetic pipeline.
// An exact hit on the first entry at or below the voltage gives its percent;
// between entries the result is truncated and capped at 99, so 100 appears
// only on an exact match with the top entry. No reset sweep is needed.
// ----------------------------------------------------------------------------
module battery_charge_from_voltage_lut (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [15:0] s_tdata,  // [15:0] voltage_mv
    input  logic [1:0]  s_tuser,  // [1:0] chem_code
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [6:0] charge_percent, [7] zero
);

    bcv_pkg::op_t              front_op;
    bcv_pkg::op_t              queue_op;
    logic                      queue_valid;
    logic                      back_pop;
    logic [bcv_pkg::PCT_W-1:0] charge;

    // Classify the incoming item straight from the ports.
    bcv_front u_front (
        .voltage_mv (s_tdata),
        .chem_code  (s_tuser),
        .op         (front_op)
    );

    // Hold classified items until the pipeline takes them.
    bcv_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (front_op),
        .out_valid (queue_valid),
        .out_pop   (back_pop),
        .out_op    (queue_op)
    );

    // Interpolate, divide and cap; stall as a whole on output backpressure.
    bcv_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (queue_valid),
        .in_pop         (back_pop),
        .in_op          (queue_op),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .charge_percent (charge)
    );

    assign m_tdata = {1'b0, charge};

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for battery_charge_from_voltage_lut
// Streams voltage/type items into the lookup and checks every charge percent
// against a local table scan with interpolation. A short directed table comes
// first, then constrained-by-hand random items, with bursty input and a
// patterned output stall.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MV_W   = bcv_pkg::MV_W;
    localparam int PCT_W  = bcv_pkg::PCT_W;
    localparam int TYPE_W = bcv_pkg::TYPE_W;
    localparam logic [TYPE_W-1:0] TYPE_LFP  = bcv_pkg::TYPE_LFP;
    localparam logic [TYPE_W-1:0] TYPE_LIPO = bcv_pkg::TYPE_LIPO;

    // Battery type codes that select no table.
    localparam logic [TYPE_W-1:0] TYPE_UNKNOWN_LO = 2'd2;
    localparam logic [TYPE_W-1:0] TYPE_UNKNOWN_HI = 2'd3;

    localparam int RANDOM_ITEMS = 1176;
    localparam int DRAIN_CYCLES = 40;       // well beyond the pipeline latency; allow plenty
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SLOTS        = 16;
    localparam int unsigned CHARGE_CAP = 99;

    // Local copy of the two discharge curves, padded to the slot count.
    // The iron phosphate curve keeps its out-of-order 26400 mV point.
    localparam int unsigned LFP_COUNT  = 11;
    localparam int unsigned LIPO_COUNT = 6;
    localparam int unsigned LFP_V [SLOTS] = '{
        27200, 26800, 26600, 26100, 26400, 26100, 26000, 25800,
        25600, 24000, 20000, 0, 0, 0, 0, 0
    };
    localparam int unsigned LFP_P [SLOTS] = '{
        100, 90, 80, 70, 60, 50, 40, 30, 20, 10, 0, 0, 0, 0, 0, 0
    };
    localparam int unsigned LIPO_V [SLOTS] = '{
        25200, 24500, 23000, 21000, 20000, 18000, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };
    localparam int unsigned LIPO_P [SLOTS] = '{
        100, 90, 80, 20, 10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    // Where the scan of the curve ended, for the closing summary.
    typedef enum int {
        SCAN_EXACT,
        SCAN_ABOVE_TOP,
        SCAN_BETWEEN,
        SCAN_BELOW_END,
        SCAN_NO_TABLE
    } scan_e;

    // Output stall patterns, cycled by bits 9:8 of the cycle count.
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_LONG_STALLS,
        RX_RARE_STALLS
    } rx_mode_e;

    typedef struct {
        logic [MV_W-1:0]   mv;
        logic [TYPE_W-1:0] kind;
        logic [PCT_W-1:0]  pct;
    } charge_exp_t;

    typedef struct {
        logic [MV_W-1:0]   mv;
        logic [TYPE_W-1:0] kind;
        bit                typed;  // pct below is the known answer
        logic [PCT_W-1:0]  pct;
    } stim_row_t;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata  = '0;   // [15:0] voltage_mv
    logic [1:0]        s_tuser  = '0;   // [1:0] chem_code
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;         // [6:0] charge_percent, [7] zero pad

    charge_exp_t charge_q[$];
    stim_row_t   stim_rows[$];
    int          fail_count   = 0;
    int          result_count = 0;
    int          item_count   = 0;
    int          scan_hits[SCAN_NO_TABLE+1];
    int          burst_left   = 0;
    int          cycle_count  = 0;
    int          stall_run    = 0;

    battery_charge_from_voltage_lut u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Scan the selected curve from its first point: exact hit returns that
    // percent, a point below the voltage interpolates toward the point
    // before it (truncate, cap at 99), running off the end gives zero.
    function automatic logic [PCT_W-1:0] predict_charge(
        input  logic [MV_W-1:0]   mv,
        input  logic [TYPE_W-1:0] kind,
        output scan_e             how
    );
        int unsigned v;
        int unsigned n;
        int unsigned span;
        int unsigned step;
        int unsigned r;
        int unsigned tv [SLOTS];
        int unsigned tp [SLOTS];
        v = int'(mv);
        how = SCAN_BELOW_END;
        if (kind == TYPE_LFP) begin
            tv = LFP_V;
            tp = LFP_P;
            n  = LFP_COUNT;
        end else if (kind == TYPE_LIPO) begin
            tv = LIPO_V;
            tp = LIPO_P;
            n  = LIPO_COUNT;
        end else begin
            how = SCAN_NO_TABLE;
            return '0;
        end
        if (n > SLOTS) n = SLOTS;
        for (int i = 0; i < n; i++) begin
            if (tv[i] == v) begin
                how = SCAN_EXACT;
                return tp[i][PCT_W-1:0];
            end
            if (tv[i] < v) begin
                if (i == 0) begin
                    how = SCAN_ABOVE_TOP;
                    return CHARGE_CAP[PCT_W-1:0];
                end
                how  = SCAN_BETWEEN;
                span = tv[i-1] - tv[i];
                if (span == 0)
                    return (tp[i] > CHARGE_CAP) ? CHARGE_CAP[PCT_W-1:0] : tp[i][PCT_W-1:0];
                // a rising percent between neighbors counts as a flat step
                step = (tp[i-1] > tp[i]) ? tp[i-1] - tp[i] : 0;
                r = tp[i] + ((v - tv[i]) * step) / span;
                return (r > CHARGE_CAP) ? CHARGE_CAP[PCT_W-1:0] : r[PCT_W-1:0];
            end
        end
        return '0;
    endfunction

    task automatic add_row(input int unsigned mv, input logic [TYPE_W-1:0] kind,
                           input bit typed, input int unsigned pct);
        stim_row_t row;
        row.mv    = mv[MV_W-1:0];
        row.kind  = kind;
        row.typed = typed;
        row.pct   = pct[PCT_W-1:0];
        stim_rows.push_back(row);
    endtask

    // Present one item, hold it until accepted, then queue its expected charge.
    task automatic send_item(input logic [MV_W-1:0] mv, input logic [TYPE_W-1:0] kind,
                             input bit typed, input logic [PCT_W-1:0] typed_pct);
        charge_exp_t e;
        scan_e       how;
        s_tvalid <= 1'b1;
        s_tdata  <= mv;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        e.mv   = mv;
        e.kind = kind;
        e.pct  = predict_charge(mv, kind, how);
        if (typed) e.pct = typed_pct;
        charge_q.push_back(e);
        scan_hits[how]++;
        item_count++;
    endtask

    // Bursts of random length; a third of the bursts run straight into the
    // next one, the rest end on a gap with s_tvalid low.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
    endtask

    task automatic wait_drained();
        while (charge_q.size() != 0) @(posedge aclk);
    endtask

    // Output stall pattern and run watchdog.
    always @(posedge aclk) begin
        rx_mode_e mode;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, charge_q.size());
            $display("FAIL");
            $finish;
        end else begin
            mode = rx_mode_e'(cycle_count[9:8]);
            case (mode)
                RX_STEADY: begin
                    m_tready <= 1'b1;
                end
                RX_COIN: begin
                    m_tready <= ($urandom_range(0, 1) != 0);
                end
                RX_LONG_STALLS: begin
                    if (stall_run > 0) begin
                        stall_run <= stall_run - 1;
                        m_tready  <= 1'b0;
                    end else if ($urandom_range(0, 3) == 0) begin
                        stall_run <= $urandom_range(1, 12);
                        m_tready  <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
                default: begin
                    m_tready <= ($urandom_range(0, 7) != 0);
                end
            endcase
        end
    end

    // Check each accepted result against the oldest queued expectation.
    always @(posedge aclk) begin
        charge_exp_t e;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (charge_q.size() == 0) begin
                $error("unexpected result: charge_percent %0d with nothing pending",
                       m_tdata[PCT_W-1:0]);
                fail_count++;
            end else begin
                e = charge_q.pop_front();
                if (m_tdata[PCT_W-1:0] !== e.pct) begin
                    $error("charge_percent: expected %0d, got %0d (%0d mV, type %0d)",
                           e.pct, m_tdata[PCT_W-1:0], e.mv, e.kind);
                    fail_count++;
                end
                if (m_tdata[7] !== 1'b0) begin
                    $error("pad bit: expected 0, got %b", m_tdata[7]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int unsigned     pick;
        int unsigned     idx;
        int              near_mv;
        logic [MV_W-1:0] mv;
        logic [TYPE_W-1:0] kind;

        foreach (scan_hits[i]) scan_hits[i] = 0;

        // Directed table: field extremes, exact hits on curve points, one past
        // the top point, the out-of-order iron phosphate point, just below the
        // last point, and both unknown types. Known answers are typed in.
        add_row(0,     TYPE_LFP,        1, 0);
        add_row(65535, TYPE_LFP,        1, 99);
        add_row(27200, TYPE_LFP,        1, 100);
        add_row(27201, TYPE_LFP,        1, 99);
        add_row(27199, TYPE_LFP,        0, 0);
        add_row(26400, TYPE_LFP,        0, 0);
        add_row(26300, TYPE_LFP,        0, 0);
        add_row(26101, TYPE_LFP,        0, 0);
        add_row(26100, TYPE_LFP,        1, 70);
        add_row(24000, TYPE_LFP,        1, 10);
        add_row(20000, TYPE_LFP,        1, 0);
        add_row(19999, TYPE_LFP,        1, 0);
        add_row(25200, TYPE_LIPO,       1, 100);
        add_row(25201, TYPE_LIPO,       1, 99);
        add_row(65535, TYPE_LIPO,       1, 99);
        add_row(24500, TYPE_LIPO,       1, 90);
        add_row(22000, TYPE_LIPO,       0, 0);
        add_row(20999, TYPE_LIPO,       0, 0);
        add_row(18000, TYPE_LIPO,       1, 0);
        add_row(17999, TYPE_LIPO,       1, 0);
        add_row(0,     TYPE_LIPO,       1, 0);
        add_row(25000, TYPE_UNKNOWN_LO, 1, 0);
        add_row(0,     TYPE_UNKNOWN_LO, 1, 0);
        add_row(65535, TYPE_UNKNOWN_HI, 1, 0);

        // Hold reset, then release it once and never again.
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i]) begin
            send_item(stim_rows[i].mv, stim_rows[i].kind, stim_rows[i].typed,
                      stim_rows[i].pct);
            if (i != stim_rows.size() - 1) pace();
        end

        // Hold off input until every directed result is back.
        s_tvalid <= 1'b0;
        wait_drained();

        // Random part: mostly voltages on and around the curves of the two
        // known types, some anywhere in the field, a tenth with no table.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            kind = $urandom_range(0, 1) ? TYPE_LIPO : TYPE_LFP;
            if (pick < 45) begin
                if (kind == TYPE_LFP)
                    mv = MV_W'($urandom_range(19500, 27700));
                else
                    mv = MV_W'($urandom_range(17500, 25700));
            end else if (pick < 70) begin
                // land on or right next to a curve point
                if (kind == TYPE_LFP) begin
                    idx     = $urandom_range(0, LFP_COUNT - 1);
                    near_mv = int'(LFP_V[idx]);
                end else begin
                    idx     = $urandom_range(0, LIPO_COUNT - 1);
                    near_mv = int'(LIPO_V[idx]);
                end
                near_mv = near_mv + int'($urandom_range(0, 4)) - 2;
                mv = near_mv[MV_W-1:0];
            end else if (pick < 90) begin
                mv = MV_W'($urandom_range(0, 65535));
            end else begin
                kind = $urandom_range(0, 1) ? TYPE_UNKNOWN_HI : TYPE_UNKNOWN_LO;
                mv   = MV_W'($urandom_range(0, 65535));
            end
            send_item(mv, kind, 1'b0, '0);
            if (n == RANDOM_ITEMS / 2) begin
                // pause the sender until the pipeline has fully emptied
                s_tvalid <= 1'b0;
                wait_drained();
            end else if (n != RANDOM_ITEMS - 1) begin
                pace();
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        // Watch a while longer for stray results.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d items, checked %0d results in %0d cycles", item_count,
                 result_count, cycle_count);
        $display("scan outcomes: %0d exact, %0d interpolated, %0d above top,",
                 scan_hits[SCAN_EXACT], scan_hits[SCAN_BETWEEN],
                 scan_hits[SCAN_ABOVE_TOP]);
        $display("  %0d below end, %0d unknown type",
                 scan_hits[SCAN_BELOW_END], scan_hits[SCAN_NO_TABLE]);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
